@@ rtl/igtm_pkg.sv @@
// Shared types and constants of the greedy IoU track matcher.
package igtm_pkg;

  localparam int MAX_TRACKS_DEF = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int PORT_COORD_BITS = 12;
  localparam int ID_BITS = 32;
  localparam int KIND_BITS = 8;
  localparam int CONF_BITS = 16;
  localparam int THR_BITS = 8;
  localparam logic [THR_BITS-1:0] THR_RESET = 8'd77;
  localparam int IOU_ONE = 256;

  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_COMMIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAREA,
    S_RD,
    S_GEO,
    S_M1,
    S_M2,
    S_UNI,
    S_C1,
    S_C2,
    S_CMP,
    S_FIN
  } igtm_state_t;

endpackage

@@ rtl/igtm_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module igtm_ram
  import igtm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/iou_greedy_track_matcher.sv @@
// Top level of the greedy IoU track matcher: sequencer, shared multiplier, track tables.
//
// Usage: detections of a frame arrive on the in_ channel with in_op = 0, one per
// transaction; a transaction with in_op = 1 ends the frame and makes the tracks
// stored during it the ones that the next frame matches against. Each detection
// yields one result transaction on the out_ channel carrying the track ID (reused
// from the best matching previous track or freshly allocated) and the echoed box.
// The cfg_ channel writes the IoU threshold (IoU * 256); it is always ready.
// Work per detection: an end of frame is taken in the idle state and leaves in_ready
// high. A detection's scan visits each previous track in turn: a claimed track is
// skipped, one whose kind differs is read and dropped, one with a zero union stops
// after the area products, and any other goes on to the cross-multiplied IoU compare.
// The single shared multiplier and the one RAM read port serialise this work.
// A new detection is accepted only once the previous one has finished; in_ready is low
// while a detection is being worked on.
// The result sits in an output register; if the receiver stalls, the block holds
// the finished detection until the register frees. Reset empties both tables,
// zeroes the ID counter and loads a threshold of 77; table contents need no clearing.
module iou_greedy_track_matcher
  import igtm_pkg::*;
#(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [THR_BITS-1:0]        cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic [KIND_BITS-1:0]       in_det_kind,
  input  logic [CONF_BITS-1:0]       in_det_confidence,
  input  logic [PORT_COORD_BITS-1:0] in_box_x,
  input  logic [PORT_COORD_BITS-1:0] in_box_y,
  input  logic [PORT_COORD_BITS-1:0] in_box_w,
  input  logic [PORT_COORD_BITS-1:0] in_box_h,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ID_BITS-1:0]         out_track_id,
  output logic [KIND_BITS-1:0]       out_kind,
  output logic [CONF_BITS-1:0]       out_confidence,
  output logic [PORT_COORD_BITS-1:0] out_x,
  output logic [PORT_COORD_BITS-1:0] out_y,
  output logic [PORT_COORD_BITS-1:0] out_w,
  output logic [PORT_COORD_BITS-1:0] out_h,
  output logic                       out_table_full
);

  localparam int CB = COORD_BITS;
  localparam int SLOTS = 2 * MAX_TRACKS;
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(MAX_TRACKS + 1);
  localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int AREA = 2 * CB;
  localparam int MW = 2 * CB + 1;
  localparam int RW = ID_BITS + KIND_BITS + 4 * CB;

  igtm_state_t state_r, state_nxt;

  logic [THR_BITS-1:0]   thr_r;
  logic [CW-1:0]         prev_cnt_r, cur_cnt_r, idx_r;
  logic [MAX_TRACKS-1:0] used_r;
  logic                  bank_r;
  logic [ID_BITS-1:0]    next_id_r;

  logic [KIND_BITS-1:0]  d_kind_r;
  logic [CONF_BITS-1:0]  d_conf_r;
  logic [CB-1:0]         dx_r, dy_r, dw_r, dh_r;
  logic [CB-1:0]         tw_r, th_r, iw_r, ih_r;
  logic [ID_BITS-1:0]    tid_r, best_id_r;
  logic [AREA-1:0]       darea_r, tarea_r, inter_r;
  logic [MW-1:0]         uni_r, best_num_r, best_den_r;
  logic [2*MW-1:0]       p1_r, p2_r;
  logic                  best_hit_r;
  logic [IW-1:0]         best_i_r;

  logic                  out_valid_r;
  logic [ID_BITS-1:0]    out_id_r;
  logic [KIND_BITS-1:0]  out_kind_r;
  logic [CONF_BITS-1:0]  out_conf_r;
  logic [CB-1:0]         ox_r, oy_r, ow_r, oh_r;
  logic                  out_full_r;

  // Shared multiplier and sequencer controls
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_p;
  logic            ram_re, ram_we;
  logic [AW-1:0]   ram_raddr, ram_waddr;
  logic [RW-1:0]   ram_wdata, ram_rdata;

  logic            in_acc, out_free, idx_used, scan_done;
  logic [15:0]     ex_x, ex_y, ex_w, ex_h;

  // Track record fields
  logic [CB-1:0]        t_x, t_y, t_w, t_h;
  logic [KIND_BITS-1:0] t_kind;
  logic [ID_BITS-1:0]   t_id;
  logic [CB-1:0]        ix1, iy1;
  logic [CB:0]          ix2, iy2, ax2, ay2, bx2, by2, iw_w, ih_w;
  logic [MW-1:0]        uni_nxt;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign idx_used  = used_r[idx_r[IW-1:0]];
  assign scan_done = (idx_r >= prev_cnt_r);

  assign ex_x = 16'(in_box_x);
  assign ex_y = 16'(in_box_y);
  assign ex_w = 16'(in_box_w);
  assign ex_h = 16'(in_box_h);

  assign t_h    = ram_rdata[CB-1:0];
  assign t_w    = ram_rdata[2*CB-1:CB];
  assign t_y    = ram_rdata[3*CB-1:2*CB];
  assign t_x    = ram_rdata[4*CB-1:3*CB];
  assign t_kind = ram_rdata[4*CB+KIND_BITS-1:4*CB];
  assign t_id   = ram_rdata[RW-1:4*CB+KIND_BITS];

  // Intersection extent of stored track and detection
  always_comb begin
    ax2  = (CB+1)'(t_x) + (CB+1)'(t_w);
    ay2  = (CB+1)'(t_y) + (CB+1)'(t_h);
    bx2  = (CB+1)'(dx_r) + (CB+1)'(dw_r);
    by2  = (CB+1)'(dy_r) + (CB+1)'(dh_r);
    ix1  = (t_x > dx_r) ? t_x : dx_r;
    iy1  = (t_y > dy_r) ? t_y : dy_r;
    ix2  = (ax2 < bx2) ? ax2 : bx2;
    iy2  = (ay2 < by2) ? ay2 : by2;
    iw_w = (ix2 > (CB+1)'(ix1)) ? ix2 - (CB+1)'(ix1) : '0;
    ih_w = (iy2 > (CB+1)'(iy1)) ? iy2 - (CB+1)'(iy1) : '0;
  end

  assign uni_nxt = MW'(tarea_r) + MW'(darea_r) - MW'(inter_r);
  assign mul_p   = (2*MW)'(mul_a) * (2*MW)'(mul_b);

  assign ram_raddr = bank_r ? AW'(MAX_TRACKS) + AW'(idx_r) : AW'(idx_r);
  assign ram_waddr = bank_r ? AW'(cur_cnt_r) : AW'(MAX_TRACKS) + AW'(cur_cnt_r);
  assign ram_wdata = {(best_hit_r ? best_id_r : next_id_r), d_kind_r, dx_r, dy_r, dw_r, dh_r};

  igtm_ram #(
    .WIDTH(RW),
    .DEPTH(SLOTS)
  ) u_tracks (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_op == OP_DETECT) state_nxt = S_DAREA;
      S_DAREA: state_nxt = S_RD;
      S_RD: begin
        if (scan_done) state_nxt = S_FIN;
        else if (!idx_used) state_nxt = S_GEO;
      end
      S_GEO:   state_nxt = (t_kind == d_kind_r) ? S_M1 : S_RD;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_UNI;
      S_UNI:   state_nxt = (uni_nxt == '0) ? S_RD : S_C1;
      S_C1:    state_nxt = S_C2;
      S_C2:    state_nxt = S_CMP;
      S_CMP:   state_nxt = S_RD;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_DAREA: begin
        mul_a = MW'(dw_r);
        mul_b = MW'(dh_r);
      end
      S_RD:    ram_re = !scan_done && !idx_used;
      S_M1: begin
        mul_a = MW'(iw_r);
        mul_b = MW'(ih_r);
      end
      S_M2: begin
        mul_a = MW'(tw_r);
        mul_b = MW'(th_r);
      end
      S_C1: begin
        mul_a = MW'(inter_r);
        mul_b = best_den_r;
      end
      S_C2: begin
        mul_a = best_num_r;
        mul_b = uni_r;
      end
      S_FIN:   ram_we = out_free && (cur_cnt_r < CW'(MAX_TRACKS));
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RESET;
      prev_cnt_r  <= '0;
      cur_cnt_r   <= '0;
      used_r      <= '0;
      bank_r      <= 1'b0;
      next_id_r   <= '0;
      idx_r       <= '0;
      best_hit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      // The finish step reloads the register itself
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_op == OP_COMMIT) begin
            prev_cnt_r <= cur_cnt_r;
            cur_cnt_r  <= '0;
            used_r     <= '0;
            bank_r     <= ~bank_r;
          end
          idx_r      <= '0;
          best_hit_r <= 1'b0;
        end
        S_RD:  if (!scan_done && idx_used) idx_r <= idx_r + 1'b1;
        S_GEO: if (t_kind != d_kind_r) idx_r <= idx_r + 1'b1;
        S_UNI: if (uni_nxt == '0) idx_r <= idx_r + 1'b1;
        S_CMP: begin
          if (p1_r > p2_r) best_hit_r <= 1'b1;
          idx_r <= idx_r + 1'b1;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (best_hit_r) begin
              used_r[best_i_r] <= 1'b1;
            end else begin
              next_id_r <= next_id_r + 1'b1;
            end
            if (cur_cnt_r < CW'(MAX_TRACKS)) cur_cnt_r <= cur_cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        d_kind_r   <= in_det_kind;
        d_conf_r   <= in_det_confidence;
        dx_r       <= ex_x[CB-1:0];
        dy_r       <= ex_y[CB-1:0];
        dw_r       <= ex_w[CB-1:0];
        dh_r       <= ex_h[CB-1:0];
        best_num_r <= MW'(thr_r);
        best_den_r <= MW'(IOU_ONE);
      end
      S_DAREA: darea_r <= mul_p[AREA-1:0];
      S_GEO: begin
        tw_r  <= t_w;
        th_r  <= t_h;
        tid_r <= t_id;
        iw_r  <= iw_w[CB-1:0];
        ih_r  <= ih_w[CB-1:0];
      end
      S_M1:  inter_r <= mul_p[AREA-1:0];
      S_M2:  tarea_r <= mul_p[AREA-1:0];
      S_UNI: uni_r <= uni_nxt;
      S_C1:  p1_r <= mul_p;
      S_C2:  p2_r <= mul_p;
      S_CMP: begin
        // Keep the new leader; a tie leaves the earlier index
        if (p1_r > p2_r) begin
          best_num_r <= MW'(inter_r);
          best_den_r <= uni_r;
          best_id_r  <= tid_r;
          best_i_r   <= idx_r[IW-1:0];
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_id_r   <= best_hit_r ? best_id_r : next_id_r;
          out_kind_r <= d_kind_r;
          out_conf_r <= d_conf_r;
          ox_r       <= dx_r;
          oy_r       <= dy_r;
          ow_r       <= dw_r;
          oh_r       <= dh_r;
          out_full_r <= !(cur_cnt_r < CW'(MAX_TRACKS));
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_track_id   = out_id_r;
  assign out_kind       = out_kind_r;
  assign out_confidence = out_conf_r;
  assign out_x          = PORT_COORD_BITS'(ox_r);
  assign out_y          = PORT_COORD_BITS'(oy_r);
  assign out_w          = PORT_COORD_BITS'(ow_r);
  assign out_h          = PORT_COORD_BITS'(oh_r);
  assign out_table_full = out_full_r;

  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_COMMIT) |=> (cur_cnt_r == '0 && used_r == '0))
    else $error("frame commit did not clear the current table");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_cnt_r <= CW'(MAX_TRACKS)) && (prev_cnt_r <= CW'(MAX_TRACKS)))
    else $error("track count beyond capacity");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && best_hit_r) |-> (CW'(best_i_r) < prev_cnt_r))
    else $error("matched track outside previous table");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish step");

endmodule
